// ===== rtl/pph_pkg.sv =====
package pph_pkg;

	// commands carried by an input transaction
	typedef enum logic [1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_READ_HIGH = 2'd1,
		CMD_READ_LOW  = 2'd2,
		CMD_READ_STAT = 2'd3
	} cmd_t;

	// statistic numbers for a statistic read
	localparam logic [7:0] STAT_HIGH_CNT   = 8'd0;
	localparam logic [7:0] STAT_LOW_CNT    = 8'd1;
	localparam logic [7:0] STAT_RISE_CNT   = 8'd2;
	localparam logic [7:0] STAT_FALL_CNT   = 8'd3;
	localparam logic [7:0] STAT_GLITCH_CNT = 8'd4;
	localparam logic [7:0] STAT_MIN_HIGH   = 8'd5;
	localparam logic [7:0] STAT_MAX_HIGH   = 8'd6;
	localparam logic [7:0] STAT_SUM_HIGH   = 8'd7;
	localparam logic [7:0] STAT_MIN_LOW    = 8'd8;
	localparam logic [7:0] STAT_MAX_LOW    = 8'd9;
	localparam logic [7:0] STAT_SUM_LOW    = 8'd10;

	// configuration register indexes
	localparam logic [0:0] REG_GLITCH_THRESHOLD = 1'd0;
	localparam logic [0:0] REG_CAPTURE_LIMIT    = 1'd1;

	// register reset values and limits
	localparam logic [31:0] GLITCH_THRESHOLD_RESET = 32'd540;
	localparam logic [19:0] CAPTURE_LIMIT_RESET    = 20'd100000;
	localparam logic [19:0] MIN_CAPTURE            = 20'd100;

	// output queue depth, also the most transactions that may be in flight
	localparam int OUTQ_DEPTH = 8;

	typedef struct packed {
		cmd_t        cmd;
		logic        pin_level;
		logic [63:0] timestamp;
		logic [7:0]  query_index;
	} item_t;

	typedef struct packed {
		logic        done;
		logic        was_high;
		logic [31:0] ticks;
	} phase_t;

	typedef struct packed {
		logic        phase_done;
		logic        ended_high;
		logic [31:0] phase_ticks;
		logic        is_glitch;
		logic [63:0] read_value;
	} result_t;

	// 32-bit increment that sticks at all ones
	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		sat_inc32 = (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/pph_ram.sv =====
module pph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port returning old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pph_phase.sv =====
module pph_phase (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  pph_pkg::item_t  item,
	input  logic [19:0]     capture_limit,
	output pph_pkg::phase_t phase
);

	typedef enum logic [1:0] {
		ARM_IDLE,
		ARM_LEVEL,
		ARM_ARMED,
		ARM_TIMING
	} arm_t;

	arm_t        arm_q;
	logic        last_level_q;
	logic [63:0] last_time_q;
	logic [19:0] edges_q;

	logic        sample;
	logic        is_edge;
	logic        room;
	logic [19:0] eff_limit;
	logic [63:0] diff;

	// edge detection and capture limit
	assign sample    = valid && (item.cmd == pph_pkg::CMD_SAMPLE);
	assign is_edge   = item.pin_level != last_level_q;
	assign eff_limit = (capture_limit < pph_pkg::MIN_CAPTURE) ? pph_pkg::MIN_CAPTURE
		: capture_limit;
	assign room      = edges_q < eff_limit;

	// wrapping phase length, saturated to 32 bits
	assign diff = item.timestamp - last_time_q;

	always_comb begin
		phase.done     = sample && (arm_q == ARM_TIMING) && is_edge && room;
		phase.was_high = phase.done && !item.pin_level;
		phase.ticks    = '0;
		if (phase.done) begin
			phase.ticks = (diff[63:32] != '0) ? '1 : diff[31:0];
		end
	end

	// arming sequence and edge timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q        <= ARM_IDLE;
			last_level_q <= 1'b0;
			last_time_q  <= '0;
			edges_q      <= '0;
		end else if (sample) begin
			unique case (arm_q)
				ARM_IDLE: begin
					last_level_q <= item.pin_level;
					arm_q        <= ARM_LEVEL;
				end
				ARM_LEVEL: begin
					if (is_edge) begin
						last_level_q <= item.pin_level;
						arm_q        <= ARM_ARMED;
					end
				end
				ARM_ARMED: begin
					if (is_edge && room) begin
						last_level_q <= item.pin_level;
						last_time_q  <= item.timestamp;
						edges_q      <= edges_q + 20'd1;
						arm_q        <= ARM_TIMING;
					end
				end
				ARM_TIMING: begin
					if (is_edge && room) begin
						last_level_q <= item.pin_level;
						last_time_q  <= item.timestamp;
						edges_q      <= edges_q + 20'd1;
					end
				end
				default: begin
					arm_q <= ARM_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pph_stats.sv =====
module pph_stats (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            update,
	input  pph_pkg::phase_t phase,
	input  logic            glitch,
	input  logic [7:0]      query_index,
	output logic [63:0]     stat_value
);

	logic [31:0] high_cnt_q;
	logic [31:0] low_cnt_q;
	logic [31:0] rise_cnt_q;
	logic [31:0] fall_cnt_q;
	logic [31:0] glitch_cnt_q;
	logic [31:0] min_q [2];
	logic [31:0] max_q [2];
	logic [63:0] sum_q [2];

	logic        wh;
	logic [64:0] sum_ext;

	assign wh      = phase.was_high;
	assign sum_ext = {1'b0, sum_q[wh]} + 65'(phase.ticks);

	// per-level counts, extremes and sums, all saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_cnt_q   <= '0;
			low_cnt_q    <= '0;
			rise_cnt_q   <= '0;
			fall_cnt_q   <= '0;
			glitch_cnt_q <= '0;
			min_q[0]     <= '1;
			min_q[1]     <= '1;
			max_q[0]     <= '0;
			max_q[1]     <= '0;
			sum_q[0]     <= '0;
			sum_q[1]     <= '0;
		end else if (update) begin
			if (wh) begin
				high_cnt_q <= pph_pkg::sat_inc32(high_cnt_q);
				fall_cnt_q <= pph_pkg::sat_inc32(fall_cnt_q);
			end else begin
				low_cnt_q  <= pph_pkg::sat_inc32(low_cnt_q);
				rise_cnt_q <= pph_pkg::sat_inc32(rise_cnt_q);
			end
			if (glitch) begin
				glitch_cnt_q <= pph_pkg::sat_inc32(glitch_cnt_q);
			end
			sum_q[wh] <= sum_ext[64] ? '1 : sum_ext[63:0];
			if (phase.ticks < min_q[wh]) begin
				min_q[wh] <= phase.ticks;
			end
			if (phase.ticks > max_q[wh]) begin
				max_q[wh] <= phase.ticks;
			end
		end
	end

	// statistic read mux
	always_comb begin
		unique case (query_index)
			pph_pkg::STAT_HIGH_CNT:   stat_value = 64'(high_cnt_q);
			pph_pkg::STAT_LOW_CNT:    stat_value = 64'(low_cnt_q);
			pph_pkg::STAT_RISE_CNT:   stat_value = 64'(rise_cnt_q);
			pph_pkg::STAT_FALL_CNT:   stat_value = 64'(fall_cnt_q);
			pph_pkg::STAT_GLITCH_CNT: stat_value = 64'(glitch_cnt_q);
			pph_pkg::STAT_MIN_HIGH:   stat_value = 64'(min_q[1]);
			pph_pkg::STAT_MAX_HIGH:   stat_value = 64'(max_q[1]);
			pph_pkg::STAT_SUM_HIGH:   stat_value = sum_q[1];
			pph_pkg::STAT_MIN_LOW:    stat_value = 64'(min_q[0]);
			pph_pkg::STAT_MAX_LOW:    stat_value = 64'(max_q[0]);
			pph_pkg::STAT_SUM_LOW:    stat_value = sum_q[0];
			default:                  stat_value = '0;
		endcase
	end

endmodule

// ===== rtl/pph_hist.sv =====
module pph_hist #(
	parameter int NUM_BUCKETS  = 256,
	parameter int TICKS_PER_US = 54
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd_s2,
	input  logic        was_high_s2,
	input  logic [31:0] ticks_s2,
	input  logic        rd_s2,
	input  logic        rd_high_s2,
	input  logic [7:0]  query_index_s2,
	output logic        clearing,
	output logic [31:0] bucket_value
);

	localparam int BW    = $clog2(NUM_BUCKETS);
	localparam int AW    = BW + 1;
	// each level's half is padded to a power of two
	localparam int DEPTH = 1 << AW;
	// lengths at or above LIMIT land in the top bucket
	localparam int LIMIT = TICKS_PER_US * NUM_BUCKETS;
	localparam int XW    = $clog2(LIMIT);
	localparam int LW    = $clog2(TICKS_PER_US);
	localparam int SH    = XW + LW;
	localparam int MW    = XW + 2;
	localparam int PRW   = XW + MW;
	// rounded-up reciprocal, exact quotient for every XW-bit dividend
	localparam logic [63:0] MUL_L = ((64'd1 << SH) + 64'(TICKS_PER_US) - 64'd1)
		/ 64'(TICKS_PER_US);
	localparam logic [MW-1:0] MUL = MUL_L[MW-1:0];

	logic           upd_s3, upd_s4;
	logic           rd_s3, rd_s4;
	logic           hi_s3;
	logic           sat_s3;
	logic [PRW-1:0] prod_s3;
	logic           rd_high_s3;
	logic           rd_ok_s3, rd_ok_s4;
	logic [BW-1:0]  qidx_s3;
	logic [AW-1:0]  addr_s4;
	logic           fwd_s4;
	logic [31:0]    wdata_q;

	logic           clr_q;
	logic [AW-1:0]  clr_addr_q;

	logic [BW-1:0]  bucket_s3;
	logic [AW-1:0]  addr_s3;
	logic           re;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [31:0]    wdata;
	logic [31:0]    rdata;
	logic [31:0]    cur_s4;

	// s2 -> s3: bucket divide by reciprocal multiply, read request carried along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s3 <= 1'b0;
			rd_s3  <= 1'b0;
		end else begin
			upd_s3 <= upd_s2;
			rd_s3  <= rd_s2;
		end
	end

	always_ff @(posedge clk) begin
		hi_s3      <= was_high_s2;
		sat_s3     <= ticks_s2 >= 32'(LIMIT);
		prod_s3    <= PRW'(ticks_s2[XW-1:0]) * PRW'(MUL);
		rd_high_s3 <= rd_high_s2;
		rd_ok_s3   <= 32'(query_index_s2) < 32'(NUM_BUCKETS);
		qidx_s3    <= BW'(query_index_s2);
	end

	// s3: memory address, high buckets in the upper half
	assign bucket_s3 = sat_s3 ? BW'(NUM_BUCKETS - 1) : prod_s3[SH +: BW];
	assign addr_s3   = upd_s3 ? {hi_s3, bucket_s3} : {rd_high_s3, qidx_s3};
	assign re        = upd_s3 || rd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s4 <= 1'b0;
			rd_s4  <= 1'b0;
		end else begin
			upd_s4 <= upd_s3;
			rd_s4  <= rd_s3;
		end
	end

	// catch a write to the same bucket that the read just missed
	always_ff @(posedge clk) begin
		rd_ok_s4 <= rd_ok_s3;
		addr_s4  <= addr_s3;
		fwd_s4   <= we && (waddr == addr_s3);
		wdata_q  <= wdata;
	end

	// s4: bucket read-modify-write
	assign cur_s4       = fwd_s4 ? wdata_q : rdata;
	assign bucket_value = (rd_s4 && rd_ok_s4) ? cur_s4 : '0;

	always_comb begin
		we    = clr_q || upd_s4;
		waddr = clr_q ? clr_addr_q : addr_s4;
		wdata = clr_q ? '0 : pph_pkg::sat_inc32(cur_s4);
	end

	// clearing pass over both histograms after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clearing = clr_q;

	pph_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(addr_s3),
		.rdata(rdata)
	);

endmodule

// ===== rtl/pph_outq.sv =====
module pph_outq #(
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pph_pkg::result_t push_data,
	input  logic             pop,
	output logic             not_empty,
	output pph_pkg::result_t head
);

	localparam int PW = $clog2(DEPTH);

	pph_pkg::result_t entry_q [DEPTH];
	logic [PW:0]      wp_q;
	logic [PW:0]      rp_q;

	assign not_empty = wp_q != rp_q;
	assign head      = entry_q[rp_q[PW-1:0]];

	// pointers with a wrap bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + (PW+1)'(1);
			end
			if (pop) begin
				rp_q <= rp_q + (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q[PW-1:0]] <= push_data;
		end
	end

endmodule

// ===== rtl/pulse_phase_histogram.sv =====
// An accepted transaction passes registers s1 to s4 and the output queue. Throughput: one
// transaction per cycle while in_stall is low; the histogram read-modify-write is pipelined with
// a forwarding path, and up to eight transactions may be in the block while out_stall holds.
// Reset: arst_n resets the control state and the configuration registers; the histogram memory
// is then swept to zero, one entry per cycle over 2*NUM_BUCKETS rounded up to a power of two,
// with in_stall high. Configuration writes are taken throughout.
module pulse_phase_histogram #(
	parameter int NUM_BUCKETS  = 256,
	parameter int TICKS_PER_US = 54
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        pin_level,
	input  logic [63:0] timestamp,
	input  logic [7:0]  query_index,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        phase_done,
	output logic        ended_high,
	output logic [31:0] phase_ticks,
	output logic        is_glitch,
	output logic [63:0] read_value
);

	localparam int CW = $clog2(pph_pkg::OUTQ_DEPTH + 1);

	logic [31:0]      glitch_threshold_q;
	logic [19:0]      capture_limit_q;

	logic             in_acc;
	logic             out_acc;
	logic [CW-1:0]    inflight_q;
	logic             clearing;

	logic             v_s1, v_s2, v_s3, v_s4;
	pph_pkg::item_t   item_s1, item_s2;
	pph_pkg::phase_t  phase_s1, phase_s2;
	pph_pkg::result_t res_s2, res_s3, res_s4;
	logic             bkt_s2, bkt_s3, bkt_s4;
	logic [63:0]      stat_value;
	logic [31:0]      bucket_value;
	pph_pkg::result_t res_out;
	pph_pkg::result_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_threshold_q <= pph_pkg::GLITCH_THRESHOLD_RESET;
			capture_limit_q    <= pph_pkg::CAPTURE_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pph_pkg::REG_GLITCH_THRESHOLD: glitch_threshold_q <= cfg_data;
				pph_pkg::REG_CAPTURE_LIMIT:    capture_limit_q    <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// credit for the output queue: transactions accepted and not yet delivered
	assign in_stall = clearing || (inflight_q == CW'(pph_pkg::OUTQ_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: input register
	always_ff @(posedge clk) begin
		item_s1 <= '{cmd: pph_pkg::cmd_t'(cmd), pin_level: pin_level,
			timestamp: timestamp, query_index: query_index};
	end

	// s1: arming and phase timing
	pph_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (v_s1),
		.item         (item_s1),
		.capture_limit(capture_limit_q),
		.phase        (phase_s1)
	);

	always_ff @(posedge clk) begin
		item_s2  <= item_s1;
		phase_s2 <= phase_s1;
	end

	// s2: glitch check, statistics, statistic read
	always_comb begin
		res_s2.phase_done  = phase_s2.done;
		res_s2.ended_high  = phase_s2.was_high;
		res_s2.phase_ticks = phase_s2.ticks;
		res_s2.is_glitch   = phase_s2.done && (phase_s2.ticks < glitch_threshold_q);
		res_s2.read_value  = (item_s2.cmd == pph_pkg::CMD_READ_STAT) ? stat_value : '0;
		bkt_s2 = (item_s2.cmd == pph_pkg::CMD_READ_HIGH)
			|| (item_s2.cmd == pph_pkg::CMD_READ_LOW);
	end

	pph_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (v_s2 && phase_s2.done),
		.phase      (phase_s2),
		.glitch     (res_s2.is_glitch),
		.query_index(item_s2.query_index),
		.stat_value (stat_value)
	);

	// s2..s4: histogram buckets
	pph_hist #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.TICKS_PER_US(TICKS_PER_US)
	) u_hist (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd_s2        (v_s2 && phase_s2.done),
		.was_high_s2   (phase_s2.was_high),
		.ticks_s2      (phase_s2.ticks),
		.rd_s2         (v_s2 && bkt_s2),
		.rd_high_s2    (item_s2.cmd == pph_pkg::CMD_READ_HIGH),
		.query_index_s2(item_s2.query_index),
		.clearing      (clearing),
		.bucket_value  (bucket_value)
	);

	always_ff @(posedge clk) begin
		res_s3 <= res_s2;
		bkt_s3 <= bkt_s2;
		res_s4 <= res_s3;
		bkt_s4 <= bkt_s3;
	end

	// s4: merge bucket read into the result
	always_comb begin
		res_out = res_s4;
		if (bkt_s4) begin
			res_out.read_value = 64'(bucket_value);
		end
	end

	pph_outq #(
		.DEPTH(pph_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s4),
		.push_data(res_out),
		.pop      (out_acc),
		.not_empty(out_valid),
		.head     (head)
	);

	assign phase_done  = head.phase_done;
	assign ended_high  = head.ended_high;
	assign phase_ticks = head.phase_ticks;
	assign is_glitch   = head.is_glitch;
	assign read_value  = head.read_value;

endmodule

// ===== sim/pulse_phase_histogram_test.sv =====
`timescale 1ns / 1ps

module pulse_phase_histogram_test;

	localparam int BIN_COUNT = 256;
	localparam int TICKS_PER_US = 54;
	localparam int PIPE_LATENCY = 5;
	localparam int RECEIVER_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;

	// arming progress of the edge detector
	typedef enum logic [1:0] {
		ARM_IDLE,
		ARM_LEVEL_KNOWN,
		ARM_ARMED,
		ARM_TIMING
	} arm_t;

	typedef struct {
		pph_pkg::item_t item;
		int             gap;
	} queued_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = pph_pkg::REG_GLITCH_THRESHOLD;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = pph_pkg::CMD_SAMPLE;
	logic        pin_level = 1'b0;
	logic [63:0] timestamp = '0;
	logic [7:0]  query_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        phase_done;
	logic        ended_high;
	logic [31:0] phase_ticks;
	logic        is_glitch;
	logic [63:0] read_value;

	pulse_phase_histogram #(
		.NUM_BUCKETS(BIN_COUNT),
		.TICKS_PER_US(TICKS_PER_US)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pin_level(pin_level),
		.timestamp(timestamp),
		.query_index(query_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.phase_done(phase_done),
		.ended_high(ended_high),
		.phase_ticks(phase_ticks),
		.is_glitch(is_glitch),
		.read_value(read_value)
	);

	// shadow copy of the analyzer state
	logic [31:0] glitch_threshold_q;
	logic [19:0] capture_limit_q;
	arm_t        arm_stage;
	logic        last_level;
	logic [63:0] last_edge_ts;
	logic [19:0] edges_seen;
	logic [31:0] high_bins [BIN_COUNT];
	logic [31:0] low_bins [BIN_COUNT];
	logic [31:0] high_total, low_total, rising_edges, falling_edges, glitches;
	logic [31:0] min_ticks [2];
	logic [31:0] max_ticks [2];
	logic [63:0] sum_ticks [2];

	queued_cmd_t      command_queue[$];
	pph_pkg::result_t predicted_results[$];
	queued_cmd_t      next_cmd;
	pph_pkg::item_t   offered_item;
	logic [63:0]      gen_time = '0;
	logic             gen_level = 1'b0;
	bit               drive_gaps = 1'b1;
	bit               stall_enable = 1'b1;
	bit               hold_request = 1'b0;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	int               items_accepted = 0;
	int               results_checked = 0;
	int               phases_timed = 0;
	int               edges_dropped = 0;
	int               mismatch_count = 0;

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] bump32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [63:0] stat_value(input logic [7:0] idx);
		unique case (idx)
		pph_pkg::STAT_HIGH_CNT:   return 64'(high_total);
		pph_pkg::STAT_LOW_CNT:    return 64'(low_total);
		pph_pkg::STAT_RISE_CNT:   return 64'(rising_edges);
		pph_pkg::STAT_FALL_CNT:   return 64'(falling_edges);
		pph_pkg::STAT_GLITCH_CNT: return 64'(glitches);
		pph_pkg::STAT_MIN_HIGH:   return 64'(min_ticks[1]);
		pph_pkg::STAT_MAX_HIGH:   return 64'(max_ticks[1]);
		pph_pkg::STAT_SUM_HIGH:   return sum_ticks[1];
		pph_pkg::STAT_MIN_LOW:    return 64'(min_ticks[0]);
		pph_pkg::STAT_MAX_LOW:    return 64'(max_ticks[0]);
		pph_pkg::STAT_SUM_LOW:    return sum_ticks[0];
		default:                  return 64'd0;
		endcase
	endfunction

	task automatic clear_model();
		glitch_threshold_q = pph_pkg::GLITCH_THRESHOLD_RESET;
		capture_limit_q = pph_pkg::CAPTURE_LIMIT_RESET;
		arm_stage = ARM_IDLE;
		last_level = 1'b0;
		last_edge_ts = '0;
		edges_seen = '0;
		for (int b = 0; b < BIN_COUNT; b++) begin
			high_bins[b] = '0;
			low_bins[b] = '0;
		end
		high_total = '0;
		low_total = '0;
		rising_edges = '0;
		falling_edges = '0;
		glitches = '0;
		min_ticks[0] = '1;
		min_ticks[1] = '1;
		max_ticks[0] = '0;
		max_ticks[1] = '0;
		sum_ticks[0] = '0;
		sum_ticks[1] = '0;
	endtask

	// apply one transaction to the shadow state, return the result it must produce
	function automatic pph_pkg::result_t histogram_update(input pph_pkg::item_t it);
		pph_pkg::result_t res;
		logic [19:0]      limit;
		logic [63:0]      span;
		logic [31:0]      ticks;
		logic             was_high;
		logic             glitch;
		int               bin;
		res = '0;
		limit = (capture_limit_q < pph_pkg::MIN_CAPTURE) ? pph_pkg::MIN_CAPTURE
			: capture_limit_q;
		if (it.cmd == pph_pkg::CMD_READ_HIGH || it.cmd == pph_pkg::CMD_READ_LOW) begin
			if (it.query_index < BIN_COUNT)
				res.read_value = (it.cmd == pph_pkg::CMD_READ_HIGH)
					? 64'(high_bins[it.query_index]) : 64'(low_bins[it.query_index]);
		end else if (it.cmd == pph_pkg::CMD_READ_STAT) begin
			res.read_value = stat_value(it.query_index);
		end else if (arm_stage == ARM_IDLE) begin
			last_level = it.pin_level;
			arm_stage = ARM_LEVEL_KNOWN;
		end else if (it.pin_level != last_level) begin
			if (arm_stage == ARM_LEVEL_KNOWN) begin
				last_level = it.pin_level;
				arm_stage = ARM_ARMED;
			end else if (edges_seen >= limit) begin
				edges_dropped++;
			end else begin
				// an edge while timing closes the running phase
				if (arm_stage == ARM_TIMING) begin
					span = it.timestamp - last_edge_ts;
					ticks = (span > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
					was_high = ~it.pin_level;
					glitch = ticks < glitch_threshold_q;
					bin = int'(ticks / TICKS_PER_US);
					if (bin >= BIN_COUNT)
						bin = BIN_COUNT - 1;
					if (was_high) begin
						high_bins[bin] = bump32(high_bins[bin]);
						high_total = bump32(high_total);
					end else begin
						low_bins[bin] = bump32(low_bins[bin]);
						low_total = bump32(low_total);
					end
					if (sum_ticks[was_high] > ~64'd0 - 64'(ticks))
						sum_ticks[was_high] = '1;
					else
						sum_ticks[was_high] = sum_ticks[was_high] + 64'(ticks);
					if (ticks < min_ticks[was_high])
						min_ticks[was_high] = ticks;
					if (ticks > max_ticks[was_high])
						max_ticks[was_high] = ticks;
					if (it.pin_level)
						rising_edges = bump32(rising_edges);
					else
						falling_edges = bump32(falling_edges);
					if (glitch)
						glitches = bump32(glitches);
					res.phase_done = 1'b1;
					res.ended_high = was_high;
					res.phase_ticks = ticks;
					res.is_glitch = glitch;
					phases_timed++;
				end
				last_level = it.pin_level;
				last_edge_ts = it.timestamp;
				edges_seen = edges_seen + 20'd1;
				arm_stage = ARM_TIMING;
			end
		end
		return res;
	endfunction

	// mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 199);
		if (pick < 120)
			return 0;
		if (pick < 180)
			return $urandom_range(1, 3);
		if (pick < 197)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] span_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return 64'd0;
		if (pick < 45)
			return 64'($urandom_range(1, 1200));
		if (pick < 85)
			return 64'($urandom_range(1, 15000));
		if (pick < 95)
			return 64'($urandom);
		return {30'd0, 2'($urandom_range(1, 3)), 32'($urandom)};
	endfunction

	function automatic logic [7:0] bucket_pick();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 24));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_item(input pph_pkg::cmd_t c, input logic lvl, input logic [63:0] ts,
			input logic [7:0] qi);
		queued_cmd_t q;
		q.item.cmd = c;
		q.item.pin_level = lvl;
		q.item.timestamp = ts;
		q.item.query_index = qi;
		q.gap = drive_gaps ? idle_length() : 0;
		command_queue.push_back(q);
	endtask

	// mostly clean edge trains, with repeated levels, time jumps and reads mixed in
	task automatic add_random_command();
		int          pick;
		logic [63:0] noise_ts;
		pick = $urandom_range(0, 99);
		noise_ts = {32'($urandom), 32'($urandom)};
		if (pick < 60) begin
			gen_level = ~gen_level;
			gen_time = gen_time + span_length();
			add_item(pph_pkg::CMD_SAMPLE, gen_level, gen_time, 8'($urandom));
		end else if (pick < 68) begin
			gen_time = gen_time + span_length();
			add_item(pph_pkg::CMD_SAMPLE, gen_level, gen_time, 8'($urandom));
		end else if (pick < 70) begin
			gen_time = noise_ts;
			gen_level = 1'($urandom);
			add_item(pph_pkg::CMD_SAMPLE, gen_level, gen_time, 8'($urandom));
		end else if (pick < 78) begin
			add_item(pph_pkg::CMD_READ_HIGH, 1'($urandom), noise_ts, bucket_pick());
		end else if (pick < 86) begin
			add_item(pph_pkg::CMD_READ_LOW, 1'($urandom), noise_ts, bucket_pick());
		end else begin
			add_item(pph_pkg::CMD_READ_STAT, 1'($urandom), noise_ts,
				(pick < 97) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(11, 255)));
		end
	endtask

	task automatic random_phase(input int count, input bit idling);
		for (int n = 0; n < count; n++) begin
			drive_gaps = idling && ((n % 200) >= 60);
			add_random_command();
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (command_queue.size() != 0 || in_valid || predicted_results.size() != 0);
		repeat (2 * PIPE_LATENCY) @(negedge clk);
	endtask

	task automatic set_registers(input logic [31:0] threshold_word,
			input logic [31:0] limit_word);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= pph_pkg::REG_GLITCH_THRESHOLD;
		cfg_data <= threshold_word;
		glitch_threshold_q = threshold_word;
		@(posedge clk);
		cfg_index <= pph_pkg::REG_CAPTURE_LIMIT;
		cfg_data <= limit_word;
		capture_limit_q = limit_word[19:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_result();
		pph_pkg::result_t want;
		results_checked++;
		if (predicted_results.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("result with nothing pending: done=%b high=%b ticks=%0d glitch=%b value=%0h",
					phase_done, ended_high, phase_ticks, is_glitch, read_value);
			mismatch_count++;
		end else begin
			want = predicted_results.pop_front();
			if (phase_done !== want.phase_done || ended_high !== want.ended_high
					|| phase_ticks !== want.phase_ticks || is_glitch !== want.is_glitch
					|| read_value !== want.read_value) begin
				if (mismatch_count < REPORT_LIMIT) begin
					$display("result %0d mismatch", results_checked);
					$display("  expected done=%b high=%b ticks=%0d glitch=%b value=%0h",
						want.phase_done, want.ended_high, want.phase_ticks,
						want.is_glitch, want.read_value);
					$display("  actual   done=%b high=%b ticks=%0d glitch=%b value=%0h",
						phase_done, ended_high, phase_ticks, is_glitch, read_value);
				end
				mismatch_count++;
			end
		end
	endtask

	// driver: offer queued transactions, honoring gaps and input stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_results.push_back(histogram_update(offered_item));
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (command_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (command_queue[0].gap > 0) begin
					command_queue[0].gap = command_queue[0].gap - 1;
					in_valid <= 1'b0;
				end else begin
					next_cmd = command_queue.pop_front();
					offered_item = next_cmd.item;
					in_valid <= 1'b1;
					cmd <= offered_item.cmd;
					pin_level <= offered_item.pin_level;
					timestamp <= offered_item.timestamp;
					query_index <= offered_item.query_index;
				end
			end
		end
	end

	// monitor: check results and stall the output side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result();
			if (stall_left > 0)
				stall_left--;
			else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = RECEIVER_HOLD;
			end else if (stall_enable)
				stall_left = idle_length();
			out_stall <= (stall_left != 0);
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", predicted_results.size());
			$display("pulse_phase_histogram verification failed");
			$finish;
		end
	end

	// stimulus and phase sequencing
	initial begin
		clear_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset contents, arming, threshold edges, overflow bucket,
		// saturation and timestamp wrap
		@(negedge clk);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_MIN_HIGH);
		add_item(pph_pkg::CMD_READ_STAT, 1'b1, '1, 8'd200);
		add_item(pph_pkg::CMD_READ_HIGH, 1'b0, '0, 8'd255);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'd5, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'd20, 8'd255);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'd100, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'd639, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'd1179, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'd1179, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'd1500, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'd15003, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'd15003 + 64'h1_0000_0000, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'd15003 + 64'h1_FFFF_FFFF, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0);
		add_item(pph_pkg::CMD_SAMPLE, 1'b1, 64'h10, 8'd0);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_HIGH_CNT);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_RISE_CNT);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_FALL_CNT);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_GLITCH_CNT);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_MIN_HIGH);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_MAX_HIGH);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_SUM_HIGH);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_MIN_LOW);
		add_item(pph_pkg::CMD_READ_STAT, 1'b0, '0, pph_pkg::STAT_SUM_LOW);
		add_item(pph_pkg::CMD_READ_HIGH, 1'b0, '0, 8'd255);
		add_item(pph_pkg::CMD_READ_LOW, 1'b0, '0, 8'd255);
		gen_time = 64'h10;
		gen_level = 1'b1;
		wait_idle();

		// zero threshold, capture limit below the floor so capture runs out
		set_registers(32'd0, 32'd0);
		@(negedge clk);
		random_phase(300, 1'b1);
		wait_idle();

		// all-ones threshold, widest capture limit, long receiver hold-off
		set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		@(negedge clk);
		random_phase(500, 1'b1);
		hold_request = 1'b1;
		wait_idle();

		// back-to-back traffic with no idling on either side
		stall_enable = 1'b0;
		set_registers(32'($urandom_range(0, 20000)),
			{12'($urandom), 20'($urandom_range(200000, 1048575))});
		@(negedge clk);
		random_phase(300, 1'b0);
		wait_idle();

		// mid-range threshold with idling restored
		stall_enable = 1'b1;
		set_registers(32'($urandom_range(0, 20000)),
			{12'($urandom), 20'($urandom_range(200000, 1048575))});
		@(negedge clk);
		random_phase(650, 1'b1);
		wait_idle();

		$display("%0d transactions in, %0d results checked, %0d phases timed",
			items_accepted, results_checked, phases_timed);
		$display("%0d edges dropped after capture ran out, %0d mismatches",
			edges_dropped, mismatch_count);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("pulse_phase_histogram verification clean");
		else
			$display("pulse_phase_histogram verification failed");
		$finish;
	end

endmodule
